### rtl/retransmit_timer_table_assert.svh
// Assertion macros used by the checker file of the retransmit timer table.
`ifndef RETRANSMIT_TIMER_TABLE_ASSERT_SVH
`define RETRANSMIT_TIMER_TABLE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RTT_ASSERT_IMPL(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("retransmit timer table check failed");

// Next-cycle implication, disabled while reset is asserted.
`define RTT_ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("retransmit timer table check failed");

`endif

### rtl/rtt_pkg.sv
// ---------------------------------------------------------------------------
// Retransmit timer table package
// Shared types, codes and constants of the retransmit timer table.
// ---------------------------------------------------------------------------
`default_nettype none

package rtt_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 32;
  localparam int unsigned CONNECTIONS       = 16;
  localparam int unsigned PAYLOAD_SLOTS     = 1024;

  localparam int unsigned CONN_W   = $clog2(CONNECTIONS);
  localparam int unsigned HANDLE_W = $clog2(PAYLOAD_SLOTS);
  localparam int unsigned SERIAL_W = 32;
  localparam int unsigned TIME_W   = 32;

  // Configuration port.
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned PADDR_W    = 3;
  localparam int unsigned REG_IDX_W  = 1;
  localparam logic [REG_IDX_W-1:0] REG_RESEND_INTERVAL = 1'b0;
  localparam logic [TIME_W-1:0]    INTERVAL_RESET      = 32'd100;

  typedef enum logic [1:0] {
    FUNC_PUSH = 2'd0,
    FUNC_ACK  = 2'd1,
    FUNC_TICK = 2'd2
  } func_e;

  typedef enum logic [2:0] {
    ST_PUSHED  = 3'd0,
    ST_FULL    = 3'd1,
    ST_ACKED   = 3'd2,
    ST_NOMATCH = 3'd3,
    ST_RESEND  = 3'd4,
    ST_DONE    = 3'd5
  } status_e;

  typedef struct packed {
    func_e                func;
    logic [CONN_W-1:0]    conn_id;
    logic [SERIAL_W-1:0]  serial;
    logic [HANDLE_W-1:0]  payload_handle;
    logic [TIME_W-1:0]    now;
  } req_t;

  typedef struct packed {
    status_e              status;
    logic [CONN_W-1:0]    out_conn;
    logic [SERIAL_W-1:0]  out_serial;
    logic [HANDLE_W-1:0]  out_handle;
    logic                 last;
  } rsp_t;

  typedef struct packed {
    logic [CONN_W-1:0]    conn;
    logic [SERIAL_W-1:0]  serial;
    logic [HANDLE_W-1:0]  handle;
    logic [TIME_W-1:0]    sent_time;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load_req;
    logic    idx_clr;
    logic    idx_inc;
    logic    rd_next;
    logic    wr_push;
    logic    wr_restamp;
    logic    wr_shift;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    emit;
    status_e emit_status;
    logic    emit_entry;
    logic    emit_last;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    func_e func;
    logic  full;
    logic  idx_end;
    logic  idx_last;
    logic  match;
    logic  expired;
  } dp_status_t;

endpackage

`default_nettype wire

### rtl/rtt_regs.sv
// ---------------------------------------------------------------------------
// Retransmit timer table configuration registers
// APB-style register slave holding the resend interval.
// ---------------------------------------------------------------------------
`default_nettype none

module rtt_regs
  import rtt_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [PADDR_W-1:0]    paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready,
  output logic      [TIME_W-1:0]     interval_o
);

  logic [TIME_W-1:0]    interval_q;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign reg_idx = paddr[PADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && (reg_idx == REG_RESEND_INTERVAL);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= INTERVAL_RESET;
    end else if (wr_en) begin
      interval_q <= pwdata[TIME_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_RESEND_INTERVAL) begin
      prdata = interval_q;
    end
  end

  assign interval_o = interval_q;

endmodule

`default_nettype wire

### rtl/rtt_ctrl.sv
// ---------------------------------------------------------------------------
// Retransmit timer table controller
// Sequences push, ack search with close-up, and the timer scan.
// ---------------------------------------------------------------------------
`default_nettype none

module rtt_ctrl
  import rtt_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start,
  output logic            busy,
  input  wire dp_status_t status_i,
  output ctrl_cmd_t       cmd_o
);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_DISPATCH = 9'b000000010,
    S_PUSH     = 9'b000000100,
    S_ACK_RD   = 9'b000001000,
    S_ACK_CMP  = 9'b000010000,
    S_SHIFT_RD = 9'b000100000,
    S_SHIFT_WR = 9'b001000000,
    S_TICK_RD  = 9'b010000000,
    S_TICK_CMP = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load_req = 1'b1;
          cmd_o.idx_clr  = 1'b1;
          state_d        = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (status_i.func)
          FUNC_PUSH: state_d = S_PUSH;
          FUNC_ACK:  state_d = S_ACK_RD;
          FUNC_TICK: state_d = S_TICK_RD;
          default:   state_d = S_IDLE;
        endcase
      end
      S_PUSH: begin
        cmd_o.emit      = 1'b1;
        cmd_o.emit_last = 1'b1;
        if (status_i.full) begin
          cmd_o.emit_status = ST_FULL;
        end else begin
          cmd_o.wr_push     = 1'b1;
          cmd_o.cnt_inc     = 1'b1;
          cmd_o.emit_status = ST_PUSHED;
        end
        state_d = S_IDLE;
      end
      S_ACK_RD: begin
        if (status_i.idx_end) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_last   = 1'b1;
          cmd_o.emit_status = ST_NOMATCH;
          state_d           = S_IDLE;
        end else begin
          state_d = S_ACK_CMP;
        end
      end
      S_ACK_CMP: begin
        if (status_i.match) begin
          state_d = S_SHIFT_RD;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = S_ACK_RD;
        end
      end
      // Close the gap: move the entry above the index down by one slot.
      S_SHIFT_RD: begin
        if (status_i.idx_last) begin
          cmd_o.cnt_dec     = 1'b1;
          cmd_o.emit        = 1'b1;
          cmd_o.emit_last   = 1'b1;
          cmd_o.emit_status = ST_ACKED;
          state_d           = S_IDLE;
        end else begin
          cmd_o.rd_next = 1'b1;
          state_d       = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        cmd_o.wr_shift = 1'b1;
        cmd_o.idx_inc  = 1'b1;
        state_d        = S_SHIFT_RD;
      end
      S_TICK_RD: begin
        if (status_i.idx_end) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_last   = 1'b1;
          cmd_o.emit_status = ST_DONE;
          state_d           = S_IDLE;
        end else begin
          state_d = S_TICK_CMP;
        end
      end
      S_TICK_CMP: begin
        if (status_i.expired) begin
          cmd_o.wr_restamp  = 1'b1;
          cmd_o.emit        = 1'b1;
          cmd_o.emit_entry  = 1'b1;
          cmd_o.emit_status = ST_RESEND;
        end
        cmd_o.idx_inc = 1'b1;
        state_d       = S_TICK_RD;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/rtt_dpath.sv
// ---------------------------------------------------------------------------
// Retransmit timer table datapath
// Entry memory, fill count, scan index, comparators and result register.
// ---------------------------------------------------------------------------
`default_nettype none

module rtt_dpath
  import rtt_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire req_t              req_i,
  input  wire logic [TIME_W-1:0] interval_i,
  input  wire ctrl_cmd_t         cmd_i,
  output dp_status_t             status_o,
  output logic                   result_valid_o,
  output rsp_t                   rsp_o
);

  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);

  req_t              req_q;
  entry_t            entry_mem_q [TABLE_ENTRIES];
  entry_t            rd_data_q;
  logic [CNT_W-1:0]  count_q;
  logic [CNT_W-1:0]  idx_q;
  logic [CNT_W-1:0]  idx_plus1;
  logic [IDX_W-1:0]  rd_addr;
  logic [IDX_W-1:0]  wr_addr;
  entry_t            wr_data;
  logic              wr_en;
  logic [TIME_W-1:0] age;
  logic              valid_q;
  rsp_t              rsp_q;

  assign idx_plus1 = idx_q + CNT_W'(1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_q <= req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      idx_q   <= '0;
    end else begin
      if (cmd_i.cnt_inc) begin
        count_q <= count_q + CNT_W'(1);
      end else if (cmd_i.cnt_dec) begin
        count_q <= count_q - CNT_W'(1);
      end
      if (cmd_i.idx_clr) begin
        idx_q <= '0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_plus1;
      end
    end
  end

  // Single write port; the read port serves either the index or the slot above it.
  assign rd_addr = cmd_i.rd_next ? idx_plus1[IDX_W-1:0] : idx_q[IDX_W-1:0];

  always_comb begin
    wr_en   = cmd_i.wr_push || cmd_i.wr_restamp || cmd_i.wr_shift;
    wr_addr = idx_q[IDX_W-1:0];
    wr_data = rd_data_q;
    if (cmd_i.wr_push) begin
      wr_addr           = count_q[IDX_W-1:0];
      wr_data.conn      = req_q.conn_id;
      wr_data.serial    = req_q.serial;
      wr_data.handle    = req_q.payload_handle;
      wr_data.sent_time = req_q.now;
    end else if (cmd_i.wr_restamp) begin
      wr_data.sent_time = req_q.now;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      entry_mem_q[wr_addr] <= wr_data;
    end
    rd_data_q <= entry_mem_q[rd_addr];
  end

  assign age = req_q.now - rd_data_q.sent_time;

  always_comb begin
    status_o.func     = req_q.func;
    status_o.full     = (count_q == CNT_W'(TABLE_ENTRIES));
    status_o.idx_end  = (idx_q >= count_q);
    status_o.idx_last = (idx_plus1 >= count_q);
    status_o.match    = (rd_data_q.conn == req_q.conn_id) &&
                        (rd_data_q.serial == req_q.serial);
    status_o.expired  = (age >= interval_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      rsp_q.status <= cmd_i.emit_status;
      rsp_q.last   <= cmd_i.emit_last;
      if (cmd_i.emit_entry) begin
        rsp_q.out_conn   <= rd_data_q.conn;
        rsp_q.out_serial <= rd_data_q.serial;
        rsp_q.out_handle <= rd_data_q.handle;
      end else begin
        rsp_q.out_conn   <= '0;
        rsp_q.out_serial <= '0;
        rsp_q.out_handle <= '0;
      end
    end
  end

  assign result_valid_o = valid_q;
  assign rsp_o          = rsp_q;

endmodule

`default_nettype wire

### rtl/retransmit_timer_table.sv
// ---------------------------------------------------------------------------
// Retransmit timer table
// Ordered table of unacknowledged packets with push, ack and timer scan.
// ---------------------------------------------------------------------------
// A request is taken on req_i at a clock edge where start is high and busy is
// low; busy then stays high until the request's last result has been issued.
// Results appear on rsp_o for exactly one cycle each, marked by
// result_valid_o, and the receiver cannot hold them off. rsp_o.last marks the
// final result of a request. The user writes the resend interval via the APB
// port at byte address 0 only while the block is idle, which is not enforced.
// A push writes the request at the fill count or reports full. An ack compares
// entries in order and, on a match, moves each entry above it down one slot to
// close the gap. A tick scan restamps and reports each expired entry, then
// reports done. The entry memory has one write port and registered read data:
// each entry is read in one state and compared or written in the next.
// A new request can be accepted in the cycle of the final result.
// Reset empties the table and sets the resend interval to 100; no clearing
// pass is needed because the fill count bounds every read.
// ---------------------------------------------------------------------------
`default_nettype none

module retransmit_timer_table
  import rtt_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start,
  output logic                       busy,
  input  wire req_t                  req_i,
  output logic                       result_valid_o,
  output rsp_t                       rsp_o,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [PADDR_W-1:0]    paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready
);

  logic [TIME_W-1:0] interval;
  ctrl_cmd_t         cmd;
  dp_status_t        dp_status;

  rtt_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .interval_o (interval)
  );

  rtt_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .status_i (dp_status),
    .cmd_o    (cmd)
  );

  rtt_dpath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_i          (req_i),
    .interval_i     (interval),
    .cmd_i          (cmd),
    .status_o       (dp_status),
    .result_valid_o (result_valid_o),
    .rsp_o          (rsp_o)
  );

endmodule

`default_nettype wire

### rtl/rtt_chk.sv
// ---------------------------------------------------------------------------
// Retransmit timer table checker
// Port-level assertions, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "retransmit_timer_table_assert.svh"

module rtt_chk
  import rtt_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start,
  input wire logic busy,
  input wire logic result_valid_o,
  input wire rsp_t rsp_o
);

  // Every result belongs to a request that was in progress.
  `RTT_ASSERT_IMPL(a_result_while_busy, clk_i, rst_ni, result_valid_o, $past(busy))

  // Only resend results carry entry fields.
  `RTT_ASSERT_IMPL(a_idle_fields_zero, clk_i, rst_ni,
                   result_valid_o && (rsp_o.status != ST_RESEND),
                   (rsp_o.out_conn == '0) && (rsp_o.out_serial == '0) &&
                   (rsp_o.out_handle == '0))

  // A resend is never the final result; every other status is.
  `RTT_ASSERT_IMPL(a_last_flag, clk_i, rst_ni, result_valid_o,
                   rsp_o.last == (rsp_o.status != ST_RESEND))

  // The final result of a request is not followed directly by another.
  `RTT_ASSERT_NEXT(a_gap_after_last, clk_i, rst_ni,
                   result_valid_o && rsp_o.last, !result_valid_o)

  // An accepted request keeps the block busy in the next cycle.
  `RTT_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, start && !busy, busy)

endmodule

bind retransmit_timer_table rtt_chk u_rtt_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .rsp_o          (rsp_o)
);

`default_nettype wire
